// ===== src/dawg_pkg.sv =====
package dawg_pkg;

    // Fixed field widths of the external interface.
    localparam int CODE_W  = 6;
    localparam int INDEX_W = 14;

    // Command codes carried on the command field.
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LETTER = 2'd1,
        CMD_END    = 2'd2
    } t_cmd;

    // One edge record as it sits in the edge store.
    typedef struct packed {
        logic [CODE_W-1:0]  letter;
        logic [INDEX_W-1:0] child;
        logic               terminal;
        logic               last;
    } t_edge_rec;

    localparam int REC_W = $bits(t_edge_rec);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHILD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic write_edge;
        logic start_letter;
        logic start_end;
        logic load_scan;
        logic step_scan;
        logic hit;
        logic miss;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic failed;
        logic letter_match;
        logic last_sibling;
        logic scan_limit;
    } t_dp_status;

endpackage

// ===== src/dawg_ram.sv =====
module dawg_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dawg_ctrl.sv =====
module dawg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  dawg_pkg::t_dp_status i_status,
    output logic                 o_busy,
    output dawg_pkg::t_dp_cmd    o_cmd
);

    dawg_pkg::t_state r_state;
    dawg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dawg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            dawg_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    unique case (dawg_pkg::t_cmd'(i_command))
                        dawg_pkg::CMD_WRITE: begin
                            o_cmd.write_edge = 1'b1;
                        end
                        dawg_pkg::CMD_LETTER: begin
                            o_cmd.start_letter = 1'b1;
                            // A failed word ignores letters after the miss.
                            if (!i_status.failed) begin
                                n_state = dawg_pkg::ST_CHILD;
                            end
                        end
                        dawg_pkg::CMD_END: begin
                            o_cmd.start_end = 1'b1;
                            n_state         = dawg_pkg::ST_FINISH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dawg_pkg::ST_CHILD: begin
                o_cmd.load_scan = 1'b1;
                n_state         = dawg_pkg::ST_SCAN;
            end
            dawg_pkg::ST_SCAN: begin
                if (i_status.letter_match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = dawg_pkg::ST_IDLE;
                end else if (i_status.last_sibling || i_status.scan_limit) begin
                    o_cmd.miss = 1'b1;
                    n_state    = dawg_pkg::ST_IDLE;
                end else begin
                    o_cmd.step_scan = 1'b1;
                end
            end
            dawg_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = dawg_pkg::ST_IDLE;
            end
            default: begin
                n_state = dawg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dawg_datapath.sv =====
module dawg_datapath #(
    parameter int EDGE_COUNT   = 16384,
    parameter int LETTER_CODES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dawg_pkg::t_dp_cmd             i_cmd,
    output dawg_pkg::t_dp_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [dawg_pkg::INDEX_W-1:0]  i_cfg_data,
    input  logic [dawg_pkg::INDEX_W-1:0]  i_edge_index,
    input  logic [dawg_pkg::CODE_W-1:0]   i_edge_letter,
    input  logic [dawg_pkg::INDEX_W-1:0]  i_edge_child,
    input  logic                          i_edge_terminal,
    input  logic                          i_edge_last_sibling,
    input  logic [dawg_pkg::CODE_W-1:0]   i_letter_code,
    output logic                          o_word_found
);

    localparam int IDX_W = $clog2(EDGE_COUNT);
    localparam int CNT_W = $clog2(LETTER_CODES);

    logic [dawg_pkg::INDEX_W-1:0] r_root;
    logic [IDX_W-1:0]             r_cursor;
    logic                         r_failed;
    logic                         r_in_word;
    logic [IDX_W-1:0]             r_ptr;
    logic [CNT_W-1:0]             r_count;
    logic [dawg_pkg::CODE_W-1:0]  r_letter;

    logic [IDX_W-1:0]             current_edge;
    logic [IDX_W-1:0]             child_edge;
    logic [IDX_W-1:0]             next_ptr;
    logic [IDX_W-1:0]             rd_addr;
    logic                         rd_en;
    logic [dawg_pkg::REC_W-1:0]   rd_data;
    dawg_pkg::t_edge_rec          rec;
    dawg_pkg::t_edge_rec          wr_rec;

    assign rec          = dawg_pkg::t_edge_rec'(rd_data);
    assign current_edge = r_in_word ? r_cursor : IDX_W'(r_root);
    assign child_edge   = IDX_W'(rec.child);
    assign next_ptr     = r_ptr + IDX_W'(1);

    assign wr_rec.letter   = i_edge_letter;
    assign wr_rec.child    = i_edge_child;
    assign wr_rec.terminal = i_edge_terminal;
    assign wr_rec.last     = i_edge_last_sibling;

    always_comb begin
        if (i_cmd.load_scan) begin
            rd_addr = child_edge;
        end else if (i_cmd.step_scan) begin
            rd_addr = next_ptr;
        end else begin
            rd_addr = current_edge;
        end
    end

    assign rd_en = i_cmd.start_letter | i_cmd.start_end | i_cmd.load_scan | i_cmd.step_scan;

    dawg_ram #(
        .WIDTH (dawg_pkg::REC_W),
        .DEPTH (EDGE_COUNT)
    ) u_edge_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_edge),
        .i_wr_addr (IDX_W'(i_edge_index)),
        .i_wr_data (wr_rec),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root    <= '0;
            r_cursor  <= '0;
            r_failed  <= 1'b0;
            r_in_word <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root <= i_cfg_data;
            end
            if (i_cmd.start_letter) begin
                r_in_word <= 1'b1;
                r_cursor  <= current_edge;
            end
            if (i_cmd.hit) begin
                r_cursor <= r_ptr;
            end
            if (i_cmd.miss) begin
                r_failed <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cursor  <= '0;
                r_failed  <= 1'b0;
                r_in_word <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_letter) begin
            r_letter <= i_letter_code;
        end
        if (i_cmd.load_scan) begin
            r_ptr   <= child_edge;
            r_count <= '0;
        end else if (i_cmd.step_scan) begin
            r_ptr   <= next_ptr;
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_status.failed       = r_failed;
    assign o_status.letter_match = (rec.letter == r_letter);
    assign o_status.last_sibling = rec.last;
    assign o_status.scan_limit   = (r_count == CNT_W'(LETTER_CODES - 1));

    assign o_word_found = !r_failed & rec.terminal;

endmodule

// ===== src/dawg_word_lookup.sv =====
// Edge write: the block stays idle. End of word: the result strobe comes in the
// cycle after acceptance. Letter: the current edge is read to find its child
// list, then 1 to LETTER_CODES siblings are examined, one edge read per cycle
// from the edge store's single read port; a letter after a miss is ignored.
// The receiver cannot stall results. Reset is synchronous and clears the cursor,
// flags and root index; the edge store is not cleared and needs no clearing pass.
module dawg_word_lookup #(
    parameter int EDGE_COUNT   = 16384,   // edge store depth, a power of two
    parameter int LETTER_CODES = 64       // longest sibling scan in edges
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Command channel.
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_command,
    input  logic [dawg_pkg::INDEX_W-1:0] i_edge_index,
    input  logic [dawg_pkg::CODE_W-1:0]  i_edge_letter,
    input  logic [dawg_pkg::INDEX_W-1:0] i_edge_child,
    input  logic                         i_edge_terminal,
    input  logic                         i_edge_last_sibling,
    input  logic [dawg_pkg::CODE_W-1:0]  i_letter_code,
    // Result strobe.
    output logic                         o_result_valid,
    output logic                         o_word_found,
    // Root edge register write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dawg_pkg::INDEX_W-1:0] i_cfg_data
);

    // The controller sequences each command word: an edge write goes straight
    // into the store, a letter reads the current edge to find its child list
    // and then walks the siblings one read per cycle, and an end of word reads
    // the current edge to report its terminal mark. The datapath owns the
    // edge store, the cursor, the failure latch and the sibling scan pointer.

    dawg_pkg::t_dp_cmd    dp_cmd;
    dawg_pkg::t_dp_status dp_status;

    // The root index is only meant to change between words, so writes are
    // taken whenever no command is in flight.
    assign o_cfg_ready    = !busy;
    assign o_result_valid = dp_cmd.finish;

    dawg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_busy    (busy),
        .o_cmd     (dp_cmd)
    );

    dawg_datapath #(
        .EDGE_COUNT   (EDGE_COUNT),
        .LETTER_CODES (LETTER_CODES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_cfg_we            (i_cfg_valid & o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_edge_index        (i_edge_index),
        .i_edge_letter       (i_edge_letter),
        .i_edge_child        (i_edge_child),
        .i_edge_terminal     (i_edge_terminal),
        .i_edge_last_sibling (i_edge_last_sibling),
        .i_letter_code       (i_letter_code),
        .o_word_found        (o_word_found)
    );

endmodule

// ===== src/dawg_checker.sv =====
module dawg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_command,
    input logic       o_result_valid
);

    logic end_accept;

    assign end_accept = start && !busy && (i_command == dawg_pkg::CMD_END);

    // Every end of word gives its result in the very next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_accept |=> o_result_valid)
        else $error("end of word without a result in the next cycle");

    // A result never appears without an end of word just before it.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(end_accept))
        else $error("result strobe without a preceding end of word");

    // One result per end of word: the strobe lasts a single cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // No new word is accepted in the cycle a result is shown.
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("block not busy while presenting a result");

endmodule

bind dawg_word_lookup dawg_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .o_result_valid (o_result_valid)
);
